>>> hw/rtl/rle_sprite_clip_decoder_defines.svh
// Assertion macros used by the decoder's checker.
`ifndef RLE_SPRITE_CLIP_DECODER_DEFINES_SVH
`define RLE_SPRITE_CLIP_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSCD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rscd check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSCD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rscd check failed");

`endif

>>> hw/rtl/rscd_pkg.sv
// Types and constants of the run-length sprite decoder.
package rscd_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OPCODE,
      PH_DX,
      PH_DY,
      PH_RUN
   } phase_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_LEFT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_TOP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TINT_COLOUR = 3'd7;

   // opcodes
   localparam logic [7:0] OP_MOVE_RIGHT = 8'd0;
   localparam logic [7:0] OP_MOVE_LEFT  = 8'd1;
   localparam logic [7:0] OP_END        = 8'd2;
   localparam logic [7:0] OP_RUN_BIAS   = 8'd2;

endpackage

>>> hw/rtl/rle_sprite_clip_decoder.sv
// Run-length sprite decoder with clip box: top level.
//
// req channel: one beat per byte of a coded sprite. tdata carries the byte,
// tuser[0] marks the first byte of a sprite (cursor jumps to the origin and
// the byte is decoded as an opcode). Bytes seen while idle without that mark
// are dropped.
// rsp channel: one beat per plotted pixel inside the clip box, plus one beat
// with tlast high (and zero data) when the end opcode arrives. Moves, run
// headers and clipped pixels produce no beat.
// csr port: plain write port, index selects origin, width, clip edges, tint.
// Write only while the decoder is idle.
//
// Throughput: one byte per cycle while req_tready is high; each byte is a single
// step of the decode state machine (one add and a handful of compares) from the
// byte to the output register. A result is registered in the output register,
// or in the skid while rsp stalls, before it shows on rsp. A two-entry output
// stage (output register plus skid) keeps req_tready registered; it drops only
// while the skid holds a beat, i.e. after rsp stalled with a result pending.
// Reset: decoder idle, cursor at zero, registers at their defaults
// (width 1, clip box 0..320 x 0..200, no tint), output stage empty.
module rle_sprite_clip_decoder #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rscd_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] stream_byte
   input  logic [0:0]                        req_tuser,   // [0] image_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rscd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] plot_x,
                                                          // [31:16] plot_y,
                                                          // [39:32] plot_colour
   output logic                              rsp_tlast,   // image_done
   input  logic                              csr_we,
   input  logic [rscd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rscd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rscd_pkg::*;

   localparam int CW    = COORD_WIDTH;
   // compare width: holds any cursor, any 16-bit edge and origin + width
   localparam int CMP_W = ((CW > 16) ? CW : 16) + 2;

   // configuration
   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic signed [15:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic        [14:0] image_width_ff;
   logic        [7:0]  tint_ff;

   // decode state
   phase_type          phase_ff, phase_in;
   logic               move_left_ff, move_left_in;
   logic [7:0]         run_left_ff, run_left_in;
   logic [CW-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;

   // output stage
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic                  out_last_ff, out_last_in, skid_last_ff, skid_last_in;

   // decode datapath
   logic                  accept;
   logic [7:0]            byte_val;
   logic                  start;
   phase_type             cur_phase;
   logic                  cur_move_left;
   logic [CW-1:0]         org_x, org_y, cx, cy, nx;
   logic signed [CMP_W-1:0] sx, sy, snx, edge_x;
   logic                  in_clip;
   logic                  res_valid;
   logic [RSP_DATA_W-1:0] res_data;
   logic                  res_last;

   assign accept   = req_tvalid && req_tready;
   assign byte_val = req_tdata;
   assign start    = req_tuser[0];

   assign org_x = CW'(origin_x_ff);
   assign org_y = CW'(origin_y_ff);

   // a sprite start overrides whatever move or run was in progress
   assign cur_phase     = start ? PH_OPCODE : phase_ff;
   assign cur_move_left = start ? 1'b0 : move_left_ff;
   assign cx            = start ? org_x : cur_x_ff;
   assign cy            = start ? org_y : cur_y_ff;

   assign sx     = CMP_W'(signed'(cx));
   assign sy     = CMP_W'(signed'(cy));
   assign nx     = cx + CW'(1);
   assign snx    = CMP_W'(signed'(nx));
   // row end is taken unwrapped: origin + width may exceed the cursor range
   assign edge_x = CMP_W'(origin_x_ff) + CMP_W'({1'b0, image_width_ff});

   assign in_clip = (sx >= CMP_W'(clip_left_ff)) && (sx < CMP_W'(clip_right_ff)) &&
                    (sy >= CMP_W'(clip_top_ff))  && (sy < CMP_W'(clip_bottom_ff));

   // next state and result of the byte on req
   always_comb begin
      phase_in     = phase_ff;
      move_left_in = move_left_ff;
      run_left_in  = run_left_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      res_valid    = 1'b0;
      res_data     = '0;
      res_last     = 1'b0;
      if (accept) begin
         phase_in     = cur_phase;
         move_left_in = cur_move_left;
         run_left_in  = start ? 8'd0 : run_left_ff;
         cur_x_in     = cx;
         cur_y_in     = cy;
         case (cur_phase)
            PH_OPCODE: begin
               case (byte_val)
                  OP_MOVE_RIGHT, OP_MOVE_LEFT: begin
                     move_left_in = (byte_val == OP_MOVE_LEFT);
                     phase_in     = PH_DX;
                  end
                  OP_END: begin
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     res_last  = 1'b1;
                  end
                  default: begin
                     run_left_in = byte_val - OP_RUN_BIAS;
                     phase_in    = PH_RUN;
                  end
               endcase
            end
            PH_DX: begin
               cur_x_in = cur_move_left ? (cx - CW'(byte_val)) : (cx + CW'(byte_val));
               phase_in = PH_DY;
            end
            PH_DY: begin
               cur_y_in = cy + CW'(byte_val);
               phase_in = PH_OPCODE;
            end
            PH_RUN: begin
               if (in_clip) begin
                  res_valid = 1'b1;
                  res_data  = {((tint_ff != 8'd0) ? tint_ff : byte_val),
                               16'(cy), 16'(cx)};
               end
               if (snx >= edge_x) begin
                  cur_x_in = org_x;
                  cur_y_in = cy + CW'(1);
               end else begin
                  cur_x_in = nx;
               end
               run_left_in = run_left_ff - 8'd1;
               if (run_left_ff == 8'd1) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: ;  // idle: byte dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         move_left_ff <= 1'b0;
         run_left_ff  <= 8'd0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         move_left_ff <= move_left_in;
         run_left_ff  <= run_left_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= 16'sd0;
         origin_y_ff    <= 16'sd0;
         image_width_ff <= 15'd1;
         clip_left_ff   <= 16'sd0;
         clip_top_ff    <= 16'sd0;
         clip_right_ff  <= 16'sd320;
         clip_bottom_ff <= 16'sd200;
         tint_ff        <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X:    origin_x_ff    <= csr_wdata;
            REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata;
            REG_IMAGE_WIDTH: image_width_ff <= csr_wdata[14:0];
            REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            REG_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            REG_TINT_COLOUR: tint_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // output register + skid; skid only fills when the output is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end else if (res_valid) begin
            out_valid_in = 1'b1;
            out_data_in  = res_data;
            out_last_in  = res_last;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res_data;
         skid_last_in  = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> hw/rtl/rscd_checker.sv
// Port-level checks of the sprite decoder, bound to its top level.
`include "rle_sprite_clip_decoder_defines.svh"

module rscd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rscd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import rscd_pkg::*;

   // end-of-image beat carries no pixel
   `RSCD_ASSERT_NOW(a_done_zero, rsp_tvalid && rsp_tlast, rsp_tdata == RSP_DATA_W'(0))

   // a beat appears only after a byte was taken
   `RSCD_ASSERT_NOW(a_rsp_from_req, $rose(rsp_tvalid), $past(req_tvalid && req_tready))

   // stalled result beat holds
   `RSCD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // input side stalls only while a result is stuck on the output
   `RSCD_ASSERT_NOW(a_ready_stall, !req_tready, rsp_tvalid)

endmodule

bind rle_sprite_clip_decoder rscd_checker u_rscd_checker (.*);
